// ----- sv/ilb_pkg.sv -----
// Shared types and constants for the indexed list buffer.
package ilb_pkg;

  localparam int DEPTH_DEF      = 16;
  localparam int VALUE_BITS_DEF = 32;

  localparam int MODE_W = 3;
  localparam int POS_W  = 5;
  localparam int DATA_W = 32;
  localparam int STAT_W = 2;
  localparam int CNT_W  = 5;

  typedef enum logic [MODE_W-1:0] {
    MODE_INS_HEAD = 3'd0,
    MODE_INS_TAIL = 3'd1,
    MODE_INS_IDX  = 3'd2,
    MODE_READ_IDX = 3'd3,
    MODE_DEL_HEAD = 3'd4,
    MODE_DEL_TAIL = 3'd5,
    MODE_DEL_IDX  = 3'd6
  } mode_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK     = 2'd0,
    ST_BADIDX = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_FULL   = 2'd3
  } status_e;

  // Shift command broadcast to every cell of the chain.
  typedef struct packed {
    logic ins;
    logic del;
  } cell_ctl_t;

endpackage

// ----- sv/ilb_cell.sv -----
// One list slot: holds, takes the left or right neighbor, or loads a new value.
module ilb_cell #(
  parameter int IDX        = 0,
  parameter int VALUE_BITS = ilb_pkg::VALUE_BITS_DEF,
  parameter int CMP_W      = 5
) (
  input  logic                  clk_i,
  input  ilb_pkg::cell_ctl_t    ctl_i,
  input  logic [CMP_W-1:0]      pos_i,
  input  logic [VALUE_BITS-1:0] new_i,
  input  logic [VALUE_BITS-1:0] left_i,
  input  logic [VALUE_BITS-1:0] right_i,
  output logic [VALUE_BITS-1:0] val_o,
  output logic [VALUE_BITS-1:0] tap_o
);

  localparam logic [CMP_W-1:0] MyIdx = CMP_W'(IDX);

  logic [VALUE_BITS-1:0] val_q, val_d;
  logic                  at_pos, past_pos;

  assign at_pos   = (pos_i == MyIdx);
  assign past_pos = (MyIdx > pos_i);

  always_comb begin
    val_d = val_q;
    if (ctl_i.ins) begin
      if (at_pos) begin
        val_d = new_i;
      end else if (past_pos) begin
        val_d = left_i;
      end
    end else if (ctl_i.del) begin
      if (at_pos || past_pos) begin
        val_d = right_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  assign val_o = val_q;
  assign tap_o = at_pos ? val_q : '0;

endmodule

// ----- sv/indexed_list_buffer.sv -----
// Indexed list buffer: ordered list of signed values held in a shifting chain of cells.
// A request returns its result with done_o registered, in the cycle after it is accepted.
// Throughput: one request per cycle; every cell shifts in the same cycle, so busy stays low.
// The result strobe done_o lasts one cycle; the receiver cannot stall it.
// Reset clears the internal entry count and the strobe; stored values and result outputs are undefined until written.
module indexed_list_buffer #(
  parameter int DEPTH      = ilb_pkg::DEPTH_DEF,
  parameter int VALUE_BITS = ilb_pkg::VALUE_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  logic [ilb_pkg::MODE_W-1:0]  mode_i,
  input  logic [ilb_pkg::POS_W-1:0]   position_i,
  input  logic [ilb_pkg::DATA_W-1:0]  item_value_i,
  output logic                        done_o,
  output logic [ilb_pkg::DATA_W-1:0]  read_value_o,
  output logic [ilb_pkg::STAT_W-1:0]  status_o,
  output logic [ilb_pkg::CNT_W-1:0]   entry_count_o
);

  // Count needs to hold DEPTH itself; position compares need room for both.
  localparam int CntW  = $clog2(DEPTH + 1);
  localparam int CmpW  = (CntW > ilb_pkg::POS_W) ? CntW : ilb_pkg::POS_W;

  logic [CntW-1:0] count_q, count_d;
  logic            done_q;
  logic [ilb_pkg::DATA_W-1:0]  rd_q, rd_d;
  ilb_pkg::status_e            st_q, st_d;
  logic [ilb_pkg::CNT_W-1:0]   cnt_out_q;

  logic [CmpW-1:0] pos_ext, cnt_ext, op_pos;
  logic            full, empty;
  ilb_pkg::cell_ctl_t ctl;
  logic            accept;

  logic [VALUE_BITS-1:0] new_val;
  logic [VALUE_BITS-1:0] cell_val [DEPTH];
  logic [VALUE_BITS-1:0] cell_tap [DEPTH];
  logic [VALUE_BITS-1:0] rd_raw;
  logic [ilb_pkg::DATA_W-1:0] rd_ext;
  logic [31:0]           cnt_wide;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  assign pos_ext = CmpW'(position_i);
  assign cnt_ext = CmpW'(count_q);
  assign full    = (count_q == CntW'(DEPTH));
  assign empty   = (count_q == '0);

  // Convert the 32-bit beat value to stored width and back.
  generate
    if (VALUE_BITS > ilb_pkg::DATA_W) begin : g_store_wide
      assign new_val = {{(VALUE_BITS - ilb_pkg::DATA_W){item_value_i[ilb_pkg::DATA_W-1]}},
                        item_value_i};
    end else begin : g_store_narrow
      assign new_val = item_value_i[VALUE_BITS-1:0];
    end
    if (VALUE_BITS >= ilb_pkg::DATA_W) begin : g_read_wide
      assign rd_ext = rd_raw[ilb_pkg::DATA_W-1:0];
    end else begin : g_read_narrow
      assign rd_ext = {{(ilb_pkg::DATA_W - VALUE_BITS){rd_raw[VALUE_BITS-1]}}, rd_raw};
    end
  endgenerate

  // Decode the request into a shift command, a target position and a status.
  always_comb begin
    ctl     = '0;
    op_pos  = pos_ext;
    st_d    = ilb_pkg::ST_OK;
    rd_d    = '0;
    count_d = count_q;
    unique case (mode_i) inside
      ilb_pkg::MODE_INS_HEAD, ilb_pkg::MODE_INS_TAIL: begin
        op_pos = (mode_i == ilb_pkg::MODE_INS_HEAD) ? '0 : cnt_ext;
        if (full) begin
          st_d = ilb_pkg::ST_FULL;
        end else begin
          ctl.ins = accept;
        end
      end
      ilb_pkg::MODE_INS_IDX: begin
        if (pos_ext > cnt_ext) begin
          st_d = ilb_pkg::ST_BADIDX;
        end else if (full) begin
          st_d = ilb_pkg::ST_FULL;
        end else begin
          ctl.ins = accept;
        end
      end
      ilb_pkg::MODE_READ_IDX: begin
        if (pos_ext >= cnt_ext) begin
          st_d = ilb_pkg::ST_BADIDX;
          rd_d = '1;
        end else begin
          rd_d = rd_ext;
        end
      end
      ilb_pkg::MODE_DEL_HEAD, ilb_pkg::MODE_DEL_TAIL: begin
        op_pos = (mode_i == ilb_pkg::MODE_DEL_HEAD) ? '0 : (cnt_ext - CmpW'(1));
        if (empty) begin
          st_d = ilb_pkg::ST_EMPTY;
        end else begin
          ctl.del = accept;
        end
      end
      ilb_pkg::MODE_DEL_IDX: begin
        if (pos_ext >= cnt_ext) begin
          st_d = ilb_pkg::ST_BADIDX;
        end else begin
          ctl.del = accept;
        end
      end
      default: begin
        st_d = ilb_pkg::ST_BADIDX;
      end
    endcase
    if (ctl.ins) begin
      count_d = count_q + CntW'(1);
    end else if (ctl.del) begin
      count_d = count_q - CntW'(1);
    end
  end

  // Chain of cells: cell i takes cell i-1 on insert and cell i+1 on delete.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [VALUE_BITS-1:0] left_v, right_v;
    if (i == 0) begin : g_first
      assign left_v = new_val;
    end else begin : g_mid_l
      assign left_v = cell_val[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right_v = '0;
    end else begin : g_mid_r
      assign right_v = cell_val[i+1];
    end
    ilb_cell #(
      .IDX        (i),
      .VALUE_BITS (VALUE_BITS),
      .CMP_W      (CmpW)
    ) u_cell (
      .clk_i   (clk_i),
      .ctl_i   (ctl),
      .pos_i   (op_pos),
      .new_i   (new_val),
      .left_i  (left_v),
      .right_i (right_v),
      .val_o   (cell_val[i]),
      .tap_o   (cell_tap[i])
    );
  end

  // Only the addressed cell drives its tap, so an OR picks the read value.
  always_comb begin
    rd_raw = '0;
    for (int i = 0; i < DEPTH; i++) begin
      rd_raw = rd_raw | cell_tap[i];
    end
  end

  assign cnt_wide = 32'(count_d);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= accept;
      if (accept) begin
        count_q <= count_d;
      end
    end
  end

  // Result payload: hold until the next accepted beat.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      rd_q      <= rd_d;
      st_q      <= st_d;
      cnt_out_q <= cnt_wide[ilb_pkg::CNT_W-1:0];
    end
  end

  assign done_o        = done_q;
  assign read_value_o  = rd_q;
  assign status_o      = st_q;
  assign entry_count_o = cnt_out_q;

endmodule
